[rtl/nsf_pkg.sv]
package nsf_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned MAX_FRAME  = 128;

  localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'd36;
  localparam logic [BYTE_W-1:0] END_CHAR_RST   = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_STAR      = 8'h2a;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_ZERO      = 8'h30;
  localparam logic [BYTE_W-1:0] HEX_TEN        = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_CHAR = 2'd0,
    REG_END_CHAR   = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_HUNT = 2'd0,
    MODE_BODY = 2'd1,
    MODE_TAIL = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_FRAME = 2'd1,
    ST_NONE  = 2'd2,
    ST_LONG  = 2'd3
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [LEN_W-1:0]   frame_length;
    logic               had_checksum;
  } result_t;

  // uppercase-only hex digit rule, value wraps to 8 bits
  function automatic logic [BYTE_W-1:0] hex_nibble(input logic [BYTE_W-1:0] d);
    logic [BYTE_W-1:0] v;
    if (d >= CHAR_UPPER_A) begin
      v = d - CHAR_UPPER_A + HEX_TEN;
    end else begin
      v = d - CHAR_ZERO;
    end
    return v;
  endfunction

endpackage

[rtl/nsf_byte_if.sv]
interface nsf_byte_if;
  logic                        valid;
  logic                        ready;
  logic [nsf_pkg::BYTE_W-1:0]  byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

[rtl/nsf_result_if.sv]
interface nsf_result_if;
  logic                        valid;
  logic                        ready;
  nsf_pkg::status_t            status;
  logic [nsf_pkg::LEN_W-1:0]   frame_length;
  logic                        had_checksum;

  modport source (output valid, output status, output frame_length, output had_checksum,
                  input ready);
  modport sink   (input valid, input status, input frame_length, input had_checksum,
                  output ready);
endinterface

[rtl/nsf_cfg_if.sv]
interface nsf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [nsf_pkg::CFG_IDX_W-1:0]  index;
  logic [nsf_pkg::BYTE_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/nmea_sentence_framer.sv]
// Channel  Dir  Payload                                   Transfer
// rx       in   byte_in[7:0]                              rx.valid & rx.ready
// frame    out  status[1:0], frame_length[7:0], had_chk   frame.valid & frame.ready
// cfg      in   index[1:0], data[7:0]                     cfg.valid & cfg.ready
//
// One result per byte; a byte can be taken every cycle while rx.ready is high, and
// its result is registered in the output register, or in the skid while it stalls.
// A two-entry output stage (register plus skid) keeps rx ready while one
// result waits; rx.ready drops only when both are full.
// rst is synchronous: hunting, start '$', end line feed, both stages empty.
module nmea_sentence_framer #(
  parameter int unsigned MAX_FRAME = nsf_pkg::MAX_FRAME
) (
  input  logic                  clk,
  input  logic                  rst,
  nsf_cfg_if.sink               cfg,
  nsf_byte_if.sink              rx,
  nsf_result_if.source          frame
);

  localparam logic [nsf_pkg::LEN_W-1:0] MaxLen = nsf_pkg::LEN_W'(MAX_FRAME);

  logic [nsf_pkg::BYTE_W-1:0] start_char;
  logic [nsf_pkg::BYTE_W-1:0] end_char;

  nsf_pkg::mode_t              mode, mode_next;
  logic [nsf_pkg::BYTE_W-1:0]  run_xor, run_xor_next;
  logic [nsf_pkg::LEN_W-1:0]   byte_count, byte_count_next;
  logic [nsf_pkg::BYTE_W-1:0]  recent [3];
  logic [nsf_pkg::BYTE_W-1:0]  recent_next [3];

  nsf_pkg::result_t res;
  nsf_pkg::result_t out_q;
  nsf_pkg::result_t skid_q;
  logic             out_valid;
  logic             skid_valid;

  logic                        accept;
  logic                        out_free;
  logic [nsf_pkg::LEN_W-1:0]   cnt_inc;
  logic [nsf_pkg::BYTE_W-1:0]  hi_nib, lo_nib, got;
  logic [nsf_pkg::BYTE_W-1:0]  b;

  assign cfg.ready = 1'b1;
  assign rx.ready  = !skid_valid;
  assign accept    = rx.valid && rx.ready;
  assign out_free  = !out_valid || frame.ready;

  assign frame.valid        = out_valid;
  assign frame.status       = out_q.status;
  assign frame.frame_length = out_q.frame_length;
  assign frame.had_checksum = out_q.had_checksum;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char <= nsf_pkg::START_CHAR_RST;
      end_char   <= nsf_pkg::END_CHAR_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        nsf_pkg::REG_START_CHAR: start_char <= cfg.data;
        nsf_pkg::REG_END_CHAR:   end_char   <= cfg.data;
        default: ;
      endcase
    end
  end

  assign b       = rx.byte_in;
  assign cnt_inc = byte_count + nsf_pkg::LEN_W'(1);
  assign hi_nib  = nsf_pkg::hex_nibble(recent[2]);
  assign lo_nib  = nsf_pkg::hex_nibble(recent[1]);
  assign got     = (hi_nib << 4) | lo_nib;

  always_comb begin
    mode_next       = mode;
    run_xor_next    = run_xor;
    byte_count_next = byte_count;
    recent_next     = recent;
    res.status       = nsf_pkg::ST_BUSY;
    res.frame_length = '0;
    res.had_checksum = 1'b0;

    case (mode)
      nsf_pkg::MODE_BODY, nsf_pkg::MODE_TAIL: begin
        byte_count_next = cnt_inc;
        if (b == end_char) begin
          mode_next = nsf_pkg::MODE_HUNT;
          res.had_checksum = (mode == nsf_pkg::MODE_TAIL);
          if ((mode == nsf_pkg::MODE_TAIL) && (got != run_xor)) begin
            res.status = nsf_pkg::ST_NONE;
          end else begin
            res.status       = nsf_pkg::ST_FRAME;
            res.frame_length = cnt_inc;
          end
        end else if (cnt_inc >= MaxLen) begin
          mode_next  = nsf_pkg::MODE_HUNT;
          res.status = nsf_pkg::ST_LONG;
        end else begin
          if (b == nsf_pkg::CHAR_STAR) begin
            mode_next = nsf_pkg::MODE_TAIL;
          end else if (mode == nsf_pkg::MODE_BODY) begin
            run_xor_next = run_xor ^ b;
          end
          recent_next[2] = recent[1];
          recent_next[1] = recent[0];
          recent_next[0] = b;
        end
      end
      default: begin
        // hunting; the unused mode code behaves the same
        if (b == start_char) begin
          mode_next       = nsf_pkg::MODE_BODY;
          run_xor_next    = '0;
          byte_count_next = nsf_pkg::LEN_W'(1);
          recent_next[2]  = '0;
          recent_next[1]  = '0;
          recent_next[0]  = b;
        end else begin
          mode_next  = nsf_pkg::MODE_HUNT;
          res.status = nsf_pkg::ST_NONE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= nsf_pkg::MODE_HUNT;
      run_xor    <= '0;
      byte_count <= '0;
      recent[0]  <= '0;
      recent[1]  <= '0;
      recent[2]  <= '0;
    end else if (accept) begin
      mode       <= mode_next;
      run_xor    <= run_xor_next;
      byte_count <= byte_count_next;
      recent     <= recent_next;
    end
  end

  // output register with skid: skid only fills while the output is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

endmodule

[tb/nmea_sentence_framer_tb.sv]
module nmea_sentence_framer_tb;
  import nsf_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              has_lit;
    result_t           lit;
  } dir_row_t;

  localparam result_t NO_LIT   = '{ST_BUSY, 8'd0, 1'b0};
  localparam result_t R_BUSY   = '{ST_BUSY, 8'd0, 1'b0};
  localparam result_t R_NONE   = '{ST_NONE, 8'd0, 1'b0};
  localparam result_t R_FRAME8 = '{ST_FRAME, 8'd8, 1'b1};
  localparam result_t R_FRAME2 = '{ST_FRAME, 8'd2, 1'b0};

  // indexes with no register behind them; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 2'd3;
  localparam logic [BYTE_W-1:0]    CHAR_CR      = 8'h0d;
  localparam logic [BYTE_W-1:0]    CHAR_DOLLAR  = 8'h24;
  localparam logic [LEN_W-1:0]     LEN_LIMIT    = LEN_W'(MAX_FRAME);

  localparam int DIR_ROWS    = 24;
  localparam int ITEM_TARGET = 1700;
  localparam int PHASE_ITEMS = 220;

  // default settings: '$' opens, LF closes
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{8'h00, 1'b1, R_NONE},   // hunting, lowest byte
    '{8'hff, 1'b1, R_NONE},   // hunting, highest byte
    '{8'h24, 1'b1, R_BUSY},   // $
    '{8'h47, 1'b1, R_BUSY},   // G
    '{8'h50, 1'b0, NO_LIT},   // P
    '{8'h2a, 1'b0, NO_LIT},   // *
    '{8'h31, 1'b0, NO_LIT},   // 1
    '{8'h37, 1'b0, NO_LIT},   // 7
    '{8'h0d, 1'b0, NO_LIT},
    '{8'h0a, 1'b1, R_FRAME8}, // "$GP*17\r\n", sum matches
    '{8'h0a, 1'b1, R_NONE},   // end char while hunting
    '{8'h24, 1'b0, NO_LIT},
    '{8'h2a, 1'b0, NO_LIT},
    '{8'h0a, 1'b0, NO_LIT},   // the high digit falls before the start: read from the cleared history
    '{8'h24, 1'b0, NO_LIT},
    '{8'h0a, 1'b1, R_FRAME2}, // shortest frame
    '{8'h24, 1'b0, NO_LIT},
    '{8'h24, 1'b0, NO_LIT},   // start char inside body is plain data
    '{8'h61, 1'b0, NO_LIT},
    '{8'h2a, 1'b0, NO_LIT},
    '{8'h66, 1'b0, NO_LIT},   // lower-case digit decodes out of range
    '{8'h46, 1'b0, NO_LIT},
    '{8'h0d, 1'b0, NO_LIT},
    '{8'h0a, 1'b0, NO_LIT}
  };

  logic clk = 1'b0;
  logic rst;

  nsf_cfg_if    cfg_ch ();
  nsf_byte_if   rx_ch ();
  nsf_result_if res_ch ();

  nmea_sentence_framer uut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_ch),
    .rx    (rx_ch),
    .frame (res_ch)
  );

  // shadow of the framer
  logic [BYTE_W-1:0] start_c = START_CHAR_RST;
  logic [BYTE_W-1:0] end_c   = END_CHAR_RST;
  mode_t             pmode   = MODE_HUNT;
  logic [BYTE_W-1:0] sum_x   = '0;
  logic [LEN_W-1:0]  nbytes  = '0;
  logic [BYTE_W-1:0] hist0 = '0, hist1 = '0, hist2 = '0;

  result_t pending_results [$];
  logic    lit_armed = 1'b0;
  result_t lit_value = NO_LIT;
  bit      calm = 1'b0;

  int n_items = 0, n_settings = 0, fails = 0;
  int n_frames = 0, n_cksum = 0, n_rejects = 0, n_long = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  function automatic result_t frame_step(input logic [BYTE_W-1:0] b);
    result_t           r;
    logic [BYTE_W-1:0] hi_d, lo_d, got;
    r = NO_LIT;
    if (pmode != MODE_BODY && pmode != MODE_TAIL) begin
      if (b == start_c) begin
        pmode  = MODE_BODY;
        sum_x  = '0;
        nbytes = LEN_W'(1);
        hist2  = '0;
        hist1  = '0;
        hist0  = b;
        r.status = ST_BUSY;
      end else begin
        pmode    = MODE_HUNT;
        r.status = ST_NONE;
      end
      return r;
    end
    nbytes = nbytes + LEN_W'(1);
    if (b == end_c) begin
      r.status       = ST_FRAME;
      r.frame_length = nbytes;
      if (pmode == MODE_TAIL) begin
        r.had_checksum = 1'b1;
        hi_d = (hist2 >= CHAR_UPPER_A) ? hist2 - CHAR_UPPER_A + HEX_TEN : hist2 - CHAR_ZERO;
        lo_d = (hist1 >= CHAR_UPPER_A) ? hist1 - CHAR_UPPER_A + HEX_TEN : hist1 - CHAR_ZERO;
        got  = {hi_d[3:0], 4'h0} | lo_d;
        if (got != sum_x) begin
          r.status       = ST_NONE;
          r.frame_length = '0;
        end
      end
      pmode = MODE_HUNT;
      return r;
    end
    if (nbytes >= LEN_LIMIT) begin
      pmode    = MODE_HUNT;
      r.status = ST_LONG;
      return r;
    end
    if (b == CHAR_STAR) pmode = MODE_TAIL;
    else if (pmode == MODE_BODY) sum_x = sum_x ^ b;
    hist2 = hist1;
    hist1 = hist0;
    hist0 = b;
    r.status = ST_BUSY;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want, r;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_START_CHAR) start_c = cfg_ch.data;
        else if (cfg_ch.index == REG_END_CHAR) end_c = cfg_ch.data;
      end
      if (rx_ch.valid && rx_ch.ready) begin
        r = frame_step(rx_ch.byte_in);
        n_items++;
        pending_results.push_back(lit_armed ? lit_value : r);
      end
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result with nothing pending: status %0d len %0d chk %0b",
                     $time, res_ch.status, res_ch.frame_length, res_ch.had_checksum);
        end else begin
          want = pending_results.pop_front();
          if (want.status !== res_ch.status || want.frame_length !== res_ch.frame_length ||
              want.had_checksum !== res_ch.had_checksum) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch: want status %0d len %0d chk %0b, got %0d %0d %0b",
                       $time, want.status, want.frame_length, want.had_checksum,
                       res_ch.status, res_ch.frame_length, res_ch.had_checksum);
          end
        end
        case (res_ch.status)
          ST_FRAME: begin
            n_frames++;
            if (res_ch.had_checksum) n_cksum++;
          end
          ST_NONE: n_rejects++;
          ST_LONG: n_long++;
          default: ;
        endcase
      end
    end
  end

  // mostly zero or short, now and then a long one
  function automatic int pick_gap(input int pct_zero);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < pct_zero) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    int stall;
    stall = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        res_ch.ready = 1'b0;
        stall--;
      end else begin
        res_ch.ready = 1'b1;
        if ($urandom_range(0, 4) == 0) stall = pick_gap(0);
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic has_lit = 1'b0,
                           input result_t lit = NO_LIT);
    int gap;
    gap = pick_gap(55);
    if (gap > 0) begin
      rx_ch.valid   = 1'b0;
      rx_ch.byte_in = 8'($urandom);
      repeat (gap) @(negedge clk);
    end
    lit_armed     = has_lit;
    lit_value     = lit;
    rx_ch.valid   = 1'b1;
    rx_ch.byte_in = b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic settle();
    rx_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CHAR_ZERO + {4'h0, n} : CHAR_UPPER_A + {4'h0, n} - HEX_TEN;
  endfunction

  function automatic logic [BYTE_W-1:0] body_byte();
    logic [BYTE_W-1:0] b;
    do begin
      if ($urandom_range(0, 9) < 7) b = 8'($urandom_range(8'h20, 8'h7e));
      else b = 8'($urandom);
    end while (b == end_c || b == CHAR_STAR);
    return b;
  endfunction

  task automatic send_sentence();
    int                kind, n, r;
    logic [BYTE_W-1:0] sum, b;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 85) n = $urandom_range(0, 12);
    else if (r < 95) n = $urandom_range(13, 60);
    else n = $urandom_range(118, 130);   // around the length limit
    send_byte(start_c);
    sum = '0;
    repeat (n) begin
      b   = body_byte();
      sum = sum ^ b;
      send_byte(b);
    end
    if (kind < 18) return;                // cut short, next bytes land in the body
    if (kind < 80) begin
      if ($urandom_range(0, 9) == 0) sum = sum ^ 8'($urandom_range(1, 255));
      send_byte(CHAR_STAR);
      send_byte(hex_char(sum[7:4]) | (($urandom_range(0, 7) == 0) ? 8'h20 : 8'h00));
      send_byte(hex_char(sum[3:0]));
      send_byte(CHAR_CR);
    end
    send_byte(end_c);
  endtask

  initial begin
    int                phase, phase_start;
    logic [BYTE_W-1:0] s, e;
    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.byte_in = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_START_CHAR;
    cfg_ch.data   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(dir_rows[i].b, dir_rows[i].has_lit, dir_rows[i].lit);

    phase = 0;
    while (n_items < ITEM_TARGET) begin
      settle();
      case (phase)
        0: begin s = CHAR_DOLLAR; e = END_CHAR_RST; end
        1: begin s = 8'h00; e = 8'hff; end
        2: begin s = 8'hff; e = 8'h00; end
        3: begin s = CHAR_DOLLAR; e = CHAR_DOLLAR; end   // end wins over start
        4: begin s = CHAR_DOLLAR; e = CHAR_STAR; end
        5: begin s = CHAR_STAR; e = END_CHAR_RST; end
        default: begin s = 8'($urandom); e = 8'($urandom); end
      endcase
      if (phase == 0) begin
        write_reg(IDX_SPARE_LO, 8'($urandom));
        write_reg(IDX_SPARE_HI, 8'($urandom));
      end else if ($urandom_range(0, 2) == 0) begin
        write_reg(($urandom_range(0, 1) == 0) ? IDX_SPARE_LO : IDX_SPARE_HI, 8'($urandom));
      end
      write_reg(REG_START_CHAR, s);
      write_reg(REG_END_CHAR, e);
      n_settings++;
      calm = (phase == 1) || ($urandom_range(0, 4) == 0);
      phase_start = n_items;
      while (n_items - phase_start < PHASE_ITEMS && n_items < ITEM_TARGET) send_sentence();
      calm = 1'b0;
      phase++;
    end
    settle();
    repeat (8) @(negedge clk);

    $display("%0d bytes under %0d char settings: %0d frames (%0d checksummed), %0d rejects,",
             n_items, n_settings, n_frames, n_cksum, n_rejects);
    $display("%0d over-length drops, %0d errors", n_long, fails);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
